// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ARP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define ARP_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/arp_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_seq_pkg
// Types, register indexes and constants of the chord arpeggiator sequencer.
// ----------------------------------------------------------------------------
package arp_seq_pkg;

  localparam int MAX_STEPS_DEF = 16;
  localparam int MAX_SPAN_DEF  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ARP_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHORD_PITCHES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SPAN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHORD_GENERATION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_STEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE      = 3'd7;

  localparam logic [1:0] PAT_UP     = 2'd0;
  localparam logic [1:0] PAT_DOWN   = 2'd1;
  localparam logic [1:0] PAT_BOUNCE = 2'd2;

  localparam int OCTAVE_Q8     = 3072;
  localparam int TEMPO_MIN_Q4  = 320;
  localparam int TEMPO_MAX_Q4  = 4800;
  localparam int BEATS_DEFAULT = 128;
  localparam int STEP_SCALE    = 960;
  localparam int GATE_NUM      = 11;
  localparam int GATE_DEN      = 20;
  localparam int RATE_RESET    = 48000;

  localparam int DIVD_W = 40;
  localparam int DIVS_W = 13;
  localparam int STEP_W = 32;

  typedef struct packed {
    logic [11:0] block_samples;
    logic [12:0] tempo_bpm;
  } in_item_t;

  typedef struct packed {
    logic               event_kind;
    logic               voice_id;
    logic signed [15:0] note_pitch;
    logic               last_event;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic do_disable;
    logic fill_init;
    logic fill_step;
    logic do_restart;
    logic mul_load;
    logic div_step_start;
    logic store_step;
    logic acc_add;
    logic acc_step;
    logic mod_sub;
    logic adv;
    logic map;
    logic rd;
    logic emit_off;
    logic emit_on;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic fill_last;
    logic restart_needed;
    logic div_busy;
    logic step_hit;
    logic mod_ge;
    logic want_off;
    logic want_on;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/chord_arpeggiator_sequencer.sv =====
// ----------------------------------------------------------------------------
// chord_arpeggiator_sequencer
// Steps an arpeggio over a stacked chord once per audio block.
// ----------------------------------------------------------------------------
// One input beat per audio block carries the sample count and the tempo.
// Each block yields zero, one or two output beats (note off, note on); the
// final beat of a block has last_event set. Registers are written through a
// plain write port; the user must write them only while the block is idle,
// which the block itself does not enforce. Each enabled block rebuilds the
// step list, one entry a cycle, to octave_span * note_count + 1 entries, at
// most MAX_STEPS. A disabled block goes straight to the event states, and a
// restart from the list build to the list read. A running block divides for
// the step length in a two-bit-per-cycle divider, accumulates and advances
// the index on a step; an index left past the period by a register change
// drops one period per subtraction. Output stalls lengthen a block.
// in_stall_o is high from acceptance until the last beat is in the output
// register. A finished beat waits in that register while out_stall_i is
// high, and the next block is accepted meanwhile.
// Reset clears the walk, the voice toggle and the output register, and loads
// the register defaults.
// ----------------------------------------------------------------------------
module chord_arpeggiator_sequencer #(
  parameter int MAX_STEPS = arp_seq_pkg::MAX_STEPS_DEF,
  parameter int MAX_SPAN  = arp_seq_pkg::MAX_SPAN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arp_seq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arp_seq_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  arp_seq_pkg::in_item_t               in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output arp_seq_pkg::out_item_t              out_data_o
);

  arp_seq_pkg::cmd_t cmd;
  arp_seq_pkg::sts_t sts;

  arp_seq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arp_seq_dp #(
    .MAX_STEPS (MAX_STEPS),
    .MAX_SPAN  (MAX_SPAN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/arp_seq_div.sv =====
// ----------------------------------------------------------------------------
// arp_seq_div
// Restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module arp_seq_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [arp_seq_pkg::DIVD_W-1:0]    dividend_i,
  input  logic [arp_seq_pkg::DIVS_W-1:0]    divisor_i,
  output logic                              busy_o,
  output logic [arp_seq_pkg::DIVD_W-1:0]    quotient_o
);

  localparam int DW      = arp_seq_pkg::DIVD_W;
  localparam int SW      = arp_seq_pkg::DIVS_W;
  localparam int NSTEPS  = DW / 2;
  localparam int CNT_W   = $clog2(NSTEPS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q, quo_d;
  logic [SW-1:0]    rem_q, rem_d, dvs_q;
  logic [SW:0]      trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int b = 0; b < 2; b++) begin
      trial = {rem_d, quo_d[DW-1]};
      quo_d = {quo_d[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = SW'(trial - {1'b0, dvs_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NSTEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// ===== hdl/arp_seq_ctrl.sv =====
// ----------------------------------------------------------------------------
// arp_seq_ctrl
// Sequencing state machine: takes each audio block through list build, step
// length division, accumulation, index advance and event output as needed.
// ----------------------------------------------------------------------------
module arp_seq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arp_seq_pkg::sts_t   sts_i,
  output arp_seq_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_DIV1   = 4'd5;
  localparam logic [3:0] S_ACC1   = 4'd6;
  localparam logic [3:0] S_ACC2   = 4'd7;
  localparam logic [3:0] S_MOD    = 4'd8;
  localparam logic [3:0] S_ADV    = 4'd9;
  localparam logic [3:0] S_MAP    = 4'd10;
  localparam logic [3:0] S_READ   = 4'd11;
  localparam logic [3:0] S_EOFF   = 4'd12;
  localparam logic [3:0] S_EON    = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts_i.enabled) begin
          cmd_o.do_disable = 1'b1;
          state_d          = S_EOFF;
        end else begin
          cmd_o.fill_init = 1'b1;
          state_d         = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          if (sts_i.restart_needed) begin
            cmd_o.do_restart = 1'b1;
            state_d          = S_MAP;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.div_step_start = 1'b1;
        state_d              = S_DIV1;
      end
      S_DIV1: begin
        if (!sts_i.div_busy) begin
          cmd_o.store_step = 1'b1;
          state_d          = S_ACC1;
        end
      end
      S_ACC1: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_ACC2;
      end
      S_ACC2: begin
        cmd_o.acc_step = 1'b1;
        state_d        = sts_i.step_hit ? S_MOD : S_EOFF;
      end
      S_MOD: begin
        if (sts_i.mod_ge) begin
          cmd_o.mod_sub = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_MAP;
        end
      end
      S_ADV: begin
        state_d = S_MAP;
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EOFF;
      end
      S_EOFF: begin
        if (!sts_i.want_off) begin
          state_d = S_EON;
        end else if (sts_i.out_free) begin
          cmd_o.emit_off = 1'b1;
          state_d        = S_EON;
        end
      end
      S_EON: begin
        if (!sts_i.want_on) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_on = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/arp_seq_dp.sv =====
// ----------------------------------------------------------------------------
// arp_seq_dp
// Datapath: configuration registers, step list, step length arithmetic,
// walk state and the output register.
// ----------------------------------------------------------------------------
module arp_seq_dp #(
  parameter int MAX_STEPS = arp_seq_pkg::MAX_STEPS_DEF,
  parameter int MAX_SPAN  = arp_seq_pkg::MAX_SPAN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arp_seq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arp_seq_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  arp_seq_pkg::in_item_t               in_data_i,
  input  arp_seq_pkg::cmd_t                   cmd_i,
  output arp_seq_pkg::sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output arp_seq_pkg::out_item_t              out_data_o
);

  localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LEN_W  = $clog2(MAX_STEPS + 1);
  localparam int IDX_W  = $clog2(2 * MAX_STEPS);
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int OFF_W  = $clog2(arp_seq_pkg::OCTAVE_Q8 * MAX_SPAN + 1);
  localparam int SUM_W  = ((OFF_W > 15) ? OFF_W : 15) + 2;
  localparam int DW     = arp_seq_pkg::DIVD_W;
  localparam int SW     = arp_seq_pkg::DIVS_W;
  localparam int STW    = arp_seq_pkg::STEP_W;
  localparam int GW     = STW + 5;

  // Configuration registers.
  logic        en_q;
  logic [1:0]  cnt_q;
  logic [47:0] pit_q;
  logic [2:0]  span_q;
  logic [1:0]  pat_q;
  logic [7:0]  gen_q;
  logic [11:0] beats_q;
  logic [17:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      cnt_q   <= '0;
      pit_q   <= '0;
      span_q  <= 3'd1;
      pat_q   <= arp_seq_pkg::PAT_UP;
      gen_q   <= '0;
      beats_q <= 12'(arp_seq_pkg::BEATS_DEFAULT);
      rate_q  <= 18'(arp_seq_pkg::RATE_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arp_seq_pkg::REG_ARP_ENABLE:       en_q    <= cfg_wdata_i[0];
        arp_seq_pkg::REG_NOTE_COUNT:       cnt_q   <= cfg_wdata_i[1:0];
        arp_seq_pkg::REG_CHORD_PITCHES:    pit_q   <= cfg_wdata_i[47:0];
        arp_seq_pkg::REG_OCTAVE_SPAN:      span_q  <= cfg_wdata_i[2:0];
        arp_seq_pkg::REG_PATTERN:          pat_q   <= cfg_wdata_i[1:0];
        arp_seq_pkg::REG_CHORD_GENERATION: gen_q   <= cfg_wdata_i[7:0];
        arp_seq_pkg::REG_BEATS_PER_STEP:   beats_q <= cfg_wdata_i[11:0];
        arp_seq_pkg::REG_SAMPLE_RATE:      rate_q  <= cfg_wdata_i[17:0];
      endcase
    end
  end

  // Three-input sort; unused slots hold the largest pitch and sink to the end.
  logic signed [15:0] srt0, srt1, srt2, swp;

  always_comb begin
    srt0 = (cnt_q > 2'd0) ? $signed(pit_q[15:0])  : 16'sh7fff;
    srt1 = (cnt_q > 2'd1) ? $signed(pit_q[31:16]) : 16'sh7fff;
    srt2 = (cnt_q > 2'd2) ? $signed(pit_q[47:32]) : 16'sh7fff;
    swp  = '0;
    if (srt0 > srt1) begin
      swp = srt0; srt0 = srt1; srt1 = swp;
    end
    if (srt1 > srt2) begin
      swp = srt1; srt1 = srt2; srt2 = swp;
    end
    if (srt0 > srt1) begin
      swp = srt0; srt0 = srt1; srt1 = swp;
    end
  end

  logic [SPAN_W-1:0] span_eff;

  always_comb begin
    if (span_q == 3'd0) begin
      span_eff = SPAN_W'(1);
    end else if (int'(span_q) > MAX_SPAN) begin
      span_eff = SPAN_W'(MAX_SPAN);
    end else begin
      span_eff = SPAN_W'(span_q);
    end
  end

  // Step list build: one entry per cycle, octave by octave, root on top.
  logic [1:0]          fi_q;
  logic [SPAN_W-1:0]   fo_q;
  logic [OFF_W-1:0]    off_q;
  logic [LEN_W-1:0]    len_q;
  logic signed [15:0]  list_q [MAX_STEPS];
  logic                fill_last, room;
  logic signed [15:0]  base, fill_val;
  logic signed [SUM_W-1:0] sum_s;

  assign fill_last = (fo_q == span_eff);
  assign room      = (len_q < LEN_W'(MAX_STEPS));

  always_comb begin
    if (fill_last) begin
      base = srt0;
    end else begin
      unique case (fi_q)
        2'd0:    base = srt0;
        2'd1:    base = srt1;
        default: base = srt2;
      endcase
    end
    sum_s = $signed({{(SUM_W-16){base[15]}}, base})
          + $signed({{(SUM_W-OFF_W){1'b0}}, off_q});
    if ((&sum_s[SUM_W-1:15]) || !(|sum_s[SUM_W-1:15])) begin
      fill_val = sum_s[15:0];
    end else begin
      fill_val = sum_s[SUM_W-1] ? 16'sh8000 : 16'sh7fff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q  <= '0;
      fo_q  <= '0;
      off_q <= '0;
      len_q <= '0;
    end else if (cmd_i.fill_init) begin
      fi_q  <= '0;
      fo_q  <= '0;
      off_q <= '0;
      len_q <= '0;
    end else if (cmd_i.fill_step) begin
      if (room) begin
        len_q <= len_q + 1'b1;
      end
      if (!fill_last) begin
        if (fi_q == cnt_q - 2'd1) begin
          fi_q  <= '0;
          fo_q  <= fo_q + 1'b1;
          off_q <= off_q + OFF_W'(arp_seq_pkg::OCTAVE_Q8);
        end else begin
          fi_q <= fi_q + 2'd1;
        end
      end
    end
  end

  // Walk period and list address.
  logic [IDX_W-1:0] period, idx_inc, map_k;
  logic [IDX_W-1:0] idx_q;
  logic [ADDR_W-1:0] addr_q;
  logic signed [15:0] pitch_q;

  always_comb begin
    if (pat_q == arp_seq_pkg::PAT_BOUNCE && len_q > LEN_W'(1)) begin
      period = IDX_W'({len_q - 1'b1, 1'b0});
    end else begin
      period = IDX_W'(len_q);
    end
    idx_inc = idx_q + 1'b1;
    if (pat_q == arp_seq_pkg::PAT_DOWN) begin
      map_k = IDX_W'(len_q) - 1'b1 - idx_q;
    end else if (pat_q == arp_seq_pkg::PAT_BOUNCE && len_q > LEN_W'(1)) begin
      map_k = (idx_q < IDX_W'(len_q)) ? idx_q : period - idx_q;
    end else begin
      map_k = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step && room) begin
      list_q[len_q[ADDR_W-1:0]] <= fill_val;
    end
    if (cmd_i.map) begin
      addr_q <= map_k[ADDR_W-1:0];
    end
    if (cmd_i.rd) begin
      pitch_q <= list_q[addr_q];
    end
  end

  // Step length through the divider.
  logic [11:0]     samp_q;
  logic [12:0]     tempo_q, tempo_c;
  logic [11:0]     beats_eff;
  logic [29:0]     prod_q;
  logic [STW-1:0]  step_q;
  logic            div_start, div_busy;
  logic [DW-1:0]   div_dividend, div_quot;
  logic [SW-1:0]   div_divisor;

  assign beats_eff = (beats_q == '0) ? 12'(arp_seq_pkg::BEATS_DEFAULT) : beats_q;

  always_comb begin
    if (tempo_q < 13'(arp_seq_pkg::TEMPO_MIN_Q4)) begin
      tempo_c = 13'(arp_seq_pkg::TEMPO_MIN_Q4);
    end else if (tempo_q > 13'(arp_seq_pkg::TEMPO_MAX_Q4)) begin
      tempo_c = 13'(arp_seq_pkg::TEMPO_MAX_Q4);
    end else begin
      tempo_c = tempo_q;
    end
  end

  assign div_start    = cmd_i.div_step_start;
  assign div_dividend = DW'(prod_q) * DW'(arp_seq_pkg::STEP_SCALE);
  assign div_divisor  = tempo_c;

  arp_seq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      samp_q  <= in_data_i.block_samples;
      tempo_q <= in_data_i.tempo_bpm;
    end
    if (cmd_i.mul_load) begin
      prod_q <= 30'(rate_q) * 30'(beats_eff);
    end
    if (cmd_i.store_step) begin
      step_q <= div_quot[STW-1:0];
    end
  end

  // Accumulator and walk state.
  logic            run_q, snd_q, svoice_q, nvb_q, woff_q, won_q;
  logic [7:0]      seen_q;
  logic [STW-1:0]  acc_q;
  logic [STW:0]    acc_sum;
  logic            step_hit, gate_hit, twice_hit;
  logic [GW-1:0]   gate_lhs, gate_rhs;

  assign acc_sum   = {1'b0, acc_q} + {{(STW-19){1'b0}}, samp_q, 8'd0};
  assign step_hit  = (acc_q >= step_q);
  assign twice_hit = ({1'b0, acc_q} >= {step_q, 1'b0});

  // The gate sits at 11/20 of the step, rounded down. acc reaches it exactly
  // when step * 11 <= acc * 20 + 19, which needs only shifts and adds.
  assign gate_lhs = GW'({step_q, 3'b0}) + GW'({step_q, 1'b0}) + GW'(step_q);
  assign gate_rhs = GW'({acc_q, 4'b0}) + GW'({acc_q, 2'b0})
                  + GW'(arp_seq_pkg::GATE_DEN - 1);
  assign gate_hit = (gate_lhs <= gate_rhs);

  logic            ov_q;
  arp_seq_pkg::out_item_t od_q;
  logic            out_free;

  assign out_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      seen_q   <= '0;
      idx_q    <= '0;
      acc_q    <= '0;
      snd_q    <= 1'b0;
      svoice_q <= 1'b0;
      nvb_q    <= 1'b0;
      woff_q   <= 1'b0;
      won_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.do_disable) begin
        woff_q <= run_q && snd_q;
        won_q  <= 1'b0;
        run_q  <= 1'b0;
      end
      if (cmd_i.do_restart) begin
        run_q  <= 1'b1;
        seen_q <= gen_q;
        idx_q  <= '0;
        acc_q  <= '0;
        woff_q <= snd_q;
        won_q  <= 1'b1;
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_sum[STW] ? '1 : acc_sum[STW-1:0];
      end
      if (cmd_i.acc_step) begin
        // A stalled accumulator that still covers a whole step starts over.
        if (step_hit) begin
          acc_q  <= twice_hit ? '0 : acc_q - step_q;
          woff_q <= snd_q;
          won_q  <= 1'b1;
        end else begin
          woff_q <= snd_q && gate_hit;
          won_q  <= 1'b0;
        end
      end
      if (cmd_i.mod_sub) begin
        idx_q <= idx_q - period;
      end
      if (cmd_i.adv) begin
        idx_q <= (idx_inc == period) ? '0 : idx_inc;
      end
      if (cmd_i.emit_off) begin
        snd_q <= 1'b0;
        ov_q  <= 1'b1;
      end else if (cmd_i.emit_on) begin
        snd_q    <= 1'b1;
        svoice_q <= nvb_q;
        nvb_q    <= ~nvb_q;
        ov_q     <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_off) begin
      od_q.event_kind <= 1'b0;
      od_q.voice_id   <= svoice_q;
      od_q.note_pitch <= '0;
      od_q.last_event <= !won_q;
    end else if (cmd_i.emit_on) begin
      od_q.event_kind <= 1'b1;
      od_q.voice_id   <= nvb_q;
      od_q.note_pitch <= pitch_q;
      od_q.last_event <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    sts_o                = '0;
    sts_o.enabled        = en_q && (cnt_q != 2'd0);
    sts_o.fill_last      = fill_last;
    sts_o.restart_needed = !run_q || (gen_q != seen_q);
    sts_o.div_busy       = div_busy;
    sts_o.step_hit       = step_hit;
    sts_o.mod_ge         = (idx_q >= period);
    sts_o.want_off       = woff_q;
    sts_o.want_on        = won_q;
    sts_o.out_free       = out_free;
  end

endmodule

// ===== hdl/arp_seq_chk.sv =====
// ----------------------------------------------------------------------------
// arp_seq_chk
// Port-level checks of the chord arpeggiator sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_seq_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input arp_seq_pkg::in_item_t   in_data_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input arp_seq_pkg::out_item_t  out_data_o
);

  // A stalled beat stays put.
  `ARP_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "output beat changed under stall")

  // An accepted block keeps the input stalled while it is worked on.
  `ARP_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "input not stalled after accept")

  `ARP_ASSERT(a_off_pitch_zero, clk_i, rst_ni, (out_valid_o && !out_data_o.event_kind) |-> (out_data_o.note_pitch == 16'sd0), "note off with nonzero pitch")

  // A note on always closes its block.
  `ARP_ASSERT(a_on_is_last, clk_i, rst_ni, (out_valid_o && out_data_o.event_kind) |-> out_data_o.last_event, "note on not marked last")

  // Reset clears the output register asynchronously, without waiting for an edge.
  `ARP_ASSERT_ANY(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind chord_arpeggiator_sequencer arp_seq_chk u_arp_seq_chk (.*);
